// ===== hdl/cphist_pkg.sv =====
// ----------------------------------------------------------------------------
// cphist_pkg
// Types and codes shared by the alignment-operation position histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package cphist_pkg;

  // transaction kinds on the op port
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // fixed field widths of the command and result ports
  localparam int unsigned CODE_IN_W  = 4;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned QPOS_W     = 10;
  localparam int unsigned RESULT_W   = 32;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_QUERY
  } state_e;

endpackage : cphist_pkg

`default_nettype wire

// ===== hdl/cphist_ram.sv =====
// ----------------------------------------------------------------------------
// cphist_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cphist_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : cphist_ram

`default_nettype wire

// ===== hdl/cigar_position_histogram.sv =====
// An in-range counter read answers from ST_QUERY; an element that counts positions
// walks them in ST_WALK and answers from ST_FLUSH; an out-of-range read or any other
// element answers straight from idle. busy is high in every state but idle, so no
// new op is taken mid-walk; one counter read-modify-write per cycle while walking; results are never held off.
// Reset: a clearing pass writes zero to every one of the NUM_CODES *
// 2**clog2(MAX_READ_LEN) RAM entries (10240 by default), with busy held high.
// ----------------------------------------------------------------------------
// cigar_position_histogram
// Saturating per-code, per-read-position counters held in one RAM, walked one
// position per cycle for each alignment element.
// ----------------------------------------------------------------------------
`default_nettype none

module cigar_position_histogram #(
  parameter int unsigned MAX_READ_LEN = 1024,
  parameter int unsigned NUM_CODES    = 10,
  parameter int unsigned COUNT_WIDTH  = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                op_i,
  input  wire logic [cphist_pkg::CODE_IN_W-1:0]    cigar_code_i,
  input  wire logic [cphist_pkg::LEN_W-1:0]        cigar_length_i,
  input  wire logic                                end_of_read_i,
  input  wire logic [cphist_pkg::CODE_IN_W-1:0]    query_code_i,
  input  wire logic [cphist_pkg::QPOS_W-1:0]       query_position_i,
  output logic                                     result_valid_o,
  output logic      [cphist_pkg::RESULT_W-1:0]     count_value_o,
  output logic                                     overflow_flag_o
);

  localparam int unsigned POS_W  = $clog2(MAX_READ_LEN);
  localparam int unsigned RP_W   = $clog2(MAX_READ_LEN + 1);
  localparam int unsigned CODE_W = $clog2(NUM_CODES);
  localparam int unsigned ADDR_W = CODE_W + POS_W;
  localparam int unsigned DEPTH  = NUM_CODES * (2 ** POS_W);
  localparam int unsigned SUM_W  = ((RP_W > cphist_pkg::LEN_W) ? RP_W : cphist_pkg::LEN_W) + 1;
  localparam logic [RP_W-1:0]   MAX_POS  = RP_W'(MAX_READ_LEN);
  localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(DEPTH - 1);

  cphist_pkg::state_e state_q, state_d;

  logic [RP_W-1:0]   rp_q, rp_d;       // running read position
  logic [RP_W-1:0]   pos_q, pos_d;     // walk position
  logic [RP_W-1:0]   stop_q, stop_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic              flag_q, flag_d;
  logic [ADDR_W-1:0] clr_q, clr_d;

  logic              pend_q;           // RMW write due this cycle
  logic [ADDR_W-1:0] waddr_q;

  logic                          result_valid_q, result_valid_d;
  logic [cphist_pkg::RESULT_W-1:0] count_value_q, count_value_d;
  logic                          overflow_flag_q, overflow_flag_d;

  logic                   ram_we, ram_re;
  logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                   accept;
  logic [SUM_W-1:0]       sum;
  logic                   past_end;
  logic [RP_W-1:0]        stop_pos;
  logic                   code_bad;
  logic                   query_bad;
  logic [63:0]            rdata_wide;
  logic [cphist_pkg::RESULT_W-1:0] rdata_sat;

  assign accept   = start && !busy;
  assign sum      = SUM_W'(rp_q) + SUM_W'(cigar_length_i);
  assign past_end = sum > SUM_W'(MAX_READ_LEN);
  assign stop_pos = past_end ? MAX_POS : RP_W'(sum);
  assign code_bad = 32'(cigar_code_i) >= NUM_CODES;
  assign query_bad = (32'(query_code_i) >= NUM_CODES) ||
                     (32'(query_position_i) >= MAX_READ_LEN);

  // counter values too large for the result port report all ones
  assign rdata_wide = 64'(ram_rdata);
  assign rdata_sat  = (|rdata_wide[63:cphist_pkg::RESULT_W]) ? '1
                                                  : rdata_wide[cphist_pkg::RESULT_W-1:0];

  // read-modify-write path and clearing pass share the write port
  assign ram_we    = pend_q || (state_q == cphist_pkg::ST_CLEAR);
  assign ram_waddr = (state_q == cphist_pkg::ST_CLEAR) ? clr_q : waddr_q;
  assign ram_wdata = (state_q == cphist_pkg::ST_CLEAR) ? '0 :
                     (&ram_rdata) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);

  always_comb begin
    state_d         = state_q;
    rp_d            = rp_q;
    pos_d           = pos_q;
    stop_d          = stop_q;
    code_d          = code_q;
    flag_d          = flag_q;
    clr_d           = clr_q;
    result_valid_d  = 1'b0;
    count_value_d   = count_value_q;
    overflow_flag_d = overflow_flag_q;
    ram_re          = 1'b0;
    ram_raddr       = {code_q, pos_q[POS_W-1:0]};
    busy            = 1'b1;

    unique case (state_q)
      cphist_pkg::ST_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == LAST_ADR) begin
          state_d = cphist_pkg::ST_IDLE;
        end
      end
      cphist_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          if (op_i == cphist_pkg::OP_READ) begin
            if (query_bad) begin
              result_valid_d  = 1'b1;
              count_value_d   = '0;
              overflow_flag_d = 1'b1;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = {CODE_W'(query_code_i), POS_W'(query_position_i)};
              state_d   = cphist_pkg::ST_QUERY;
            end
          end else begin
            rp_d   = end_of_read_i ? '0 : stop_pos;
            flag_d = past_end || code_bad;
            if (code_bad || (stop_pos == rp_q)) begin
              result_valid_d  = 1'b1;
              count_value_d   = '0;
              overflow_flag_d = past_end || code_bad;
            end else begin
              pos_d   = rp_q;
              stop_d  = stop_pos;
              code_d  = CODE_W'(cigar_code_i);
              state_d = cphist_pkg::ST_WALK;
            end
          end
        end
      end
      cphist_pkg::ST_WALK: begin
        ram_re = 1'b1;
        pos_d  = pos_q + RP_W'(1);
        if ((pos_q + RP_W'(1)) == stop_q) begin
          state_d = cphist_pkg::ST_FLUSH;
        end
      end
      cphist_pkg::ST_FLUSH: begin
        // last write-back happens this cycle
        result_valid_d  = 1'b1;
        count_value_d   = '0;
        overflow_flag_d = flag_q;
        state_d         = cphist_pkg::ST_IDLE;
      end
      cphist_pkg::ST_QUERY: begin
        result_valid_d  = 1'b1;
        count_value_d   = rdata_sat;
        overflow_flag_d = 1'b0;
        state_d         = cphist_pkg::ST_IDLE;
      end
      default: begin
        state_d = cphist_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= cphist_pkg::ST_CLEAR;
      rp_q           <= '0;
      clr_q          <= '0;
      pend_q         <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      rp_q           <= rp_d;
      clr_q          <= clr_d;
      pend_q         <= (state_q == cphist_pkg::ST_WALK);
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q           <= pos_d;
    stop_q          <= stop_d;
    code_q          <= code_d;
    flag_q          <= flag_d;
    waddr_q         <= ram_raddr;
    count_value_q   <= count_value_d;
    overflow_flag_q <= overflow_flag_d;
  end

  cphist_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_counters (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign result_valid_o  = result_valid_q;
  assign count_value_o   = count_value_q;
  assign overflow_flag_o = overflow_flag_q;

  // a write-back never races a read of the same counter
  a_no_rmw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("counter RAM read and write hit the same entry");

  // results only appear once the block has gone idle
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (state_q == cphist_pkg::ST_IDLE))
    else $error("result strobe outside idle");

  // the walk never reaches its stop position
  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cphist_pkg::ST_WALK) |-> (pos_q < stop_q))
    else $error("walk position past stop");

  // running position never passes the end of the table
  a_rp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_q <= MAX_POS)
    else $error("read position past table");

endmodule : cigar_position_histogram

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cigar_position_histogram: feeds alignment elements
// and counter reads, mirrors the counter table locally and checks each result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cphist_pkg::*;

  localparam int unsigned N_CODES  = 10;
  localparam int unsigned READ_LEN = 1024;
  localparam int unsigned CLEAR_CYCLES = 10240;
  localparam int unsigned PHASE_ITEMS  = 267;

  typedef struct {
    logic                 op;
    logic [CODE_IN_W-1:0] code;
    logic [LEN_W-1:0]     len;
    logic                 eor;
    logic [CODE_IN_W-1:0] qcode;
    logic [QPOS_W-1:0]    qpos;
    int unsigned          idle_pct;
    bit                   drain;
  } cigar_cmd_t;

  typedef struct {
    logic [RESULT_W-1:0] count;
    logic                flag;
  } tally_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic op_i = OP_ADD;
  logic [CODE_IN_W-1:0] cigar_code_i = '0;
  logic [LEN_W-1:0]     cigar_length_i = '0;
  logic                 end_of_read_i = 1'b0;
  logic [CODE_IN_W-1:0] query_code_i = '0;
  logic [QPOS_W-1:0]    query_position_i = '0;
  logic                 result_valid_o;
  logic [RESULT_W-1:0]  count_value_o;
  logic                 overflow_flag_o;

  cigar_cmd_t  cigar_cmd_q[$];
  tally_t      tally_due_q[$];
  logic [RESULT_W-1:0] hist_q [N_CODES][READ_LEN];
  int unsigned read_pos;

  int unsigned n_issued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned n_elems = 0;
  int unsigned n_reads = 0;
  int unsigned n_flagged = 0;
  int unsigned n_alignments = 0;
  longint unsigned cycle_budget = 0;
  longint unsigned cycle_limit = 64'd10_000_000;
  longint unsigned cycle_cnt = 0;

  cigar_position_histogram #(
    .MAX_READ_LEN(READ_LEN),
    .NUM_CODES   (N_CODES),
    .COUNT_WIDTH (RESULT_W)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .cigar_code_i    (cigar_code_i),
    .cigar_length_i  (cigar_length_i),
    .end_of_read_i   (end_of_read_i),
    .query_code_i    (query_code_i),
    .query_position_i(query_position_i),
    .result_valid_o  (result_valid_o),
    .count_value_o   (count_value_o),
    .overflow_flag_o (overflow_flag_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mirror of the table: walk the element or fetch one counter.
  function automatic tally_t tally_cigar_op(logic op, logic [CODE_IN_W-1:0] code,
                                            logic [LEN_W-1:0] len, logic eor,
                                            logic [CODE_IN_W-1:0] qcode,
                                            logic [QPOS_W-1:0] qpos);
    tally_t r;
    int unsigned stop;
    r.count = '0;
    r.flag  = 1'b0;
    if (op == OP_ADD) begin
      stop = read_pos + len;
      if (stop > READ_LEN) begin
        r.flag = 1'b1;
        stop = READ_LEN;
      end
      if (code >= N_CODES) begin
        r.flag = 1'b1;
      end else begin
        for (int unsigned p = read_pos; p < stop; p++) begin
          if (hist_q[code][p] != '1) hist_q[code][p] = hist_q[code][p] + 1'b1;
        end
      end
      read_pos = eor ? 0 : stop;
    end else if (qcode >= N_CODES || qpos >= READ_LEN) begin
      r.flag = 1'b1;
    end else begin
      r.count = hist_q[qcode][qpos];
    end
    return r;
  endfunction

  task automatic push_element(logic [CODE_IN_W-1:0] code, logic [LEN_W-1:0] len,
                              logic eor, int unsigned idle_pct, bit drain);
    cigar_cmd_t c;
    c.op = OP_ADD;
    c.code = code;
    c.len = len;
    c.eor = eor;
    c.qcode = CODE_IN_W'($urandom);
    c.qpos = QPOS_W'($urandom);
    c.idle_pct = idle_pct;
    c.drain = drain;
    cigar_cmd_q.push_back(c);
    cycle_budget += ((len > READ_LEN) ? READ_LEN : len) + 48;
  endtask

  task automatic push_read(logic [CODE_IN_W-1:0] qcode, logic [QPOS_W-1:0] qpos,
                           int unsigned idle_pct, bit drain);
    cigar_cmd_t c;
    c.op = OP_READ;
    c.code = CODE_IN_W'($urandom);
    c.len = LEN_W'($urandom);
    c.eor = 1'($urandom);
    c.qcode = qcode;
    c.qpos = qpos;
    c.idle_pct = idle_pct;
    c.drain = drain;
    cigar_cmd_q.push_back(c);
    cycle_budget += 48;
  endtask

  function automatic logic [LEN_W-1:0] rand_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 70) return LEN_W'($urandom_range(1, 40));
    if (r < 90) return LEN_W'($urandom_range(41, 150));
    if (r < 99) return LEN_W'($urandom_range(151, 400));
    return LEN_W'($urandom_range(401, 2047));
  endfunction

  function automatic logic [CODE_IN_W-1:0] rand_code();
    if ($urandom_range(0, 99) < 92) return CODE_IN_W'($urandom_range(0, N_CODES - 1));
    return CODE_IN_W'($urandom_range(N_CODES, 15));
  endfunction

  function automatic logic [QPOS_W-1:0] rand_qpos();
    if ($urandom_range(0, 3) != 0) return QPOS_W'($urandom_range(0, 200));
    return QPOS_W'($urandom);
  endfunction

  // One read's worth of elements; a few are left open to run past the table.
  task automatic gen_alignment(int unsigned idle_pct, bit drain, inout int unsigned cnt);
    int unsigned nelem;
    bit          closed;
    nelem = $urandom_range(1, 8);
    closed = ($urandom_range(0, 9) != 0);
    for (int unsigned i = 0; i < nelem; i++) begin
      push_element(rand_code(), rand_len(), closed && (i == nelem - 1), idle_pct,
                   drain && (i == 0));
      cnt++;
    end
    n_alignments++;
  endtask

  task automatic gen_phase(int unsigned idle_pct);
    int unsigned cnt;
    int unsigned r;
    int unsigned nq;
    bit          first;
    cnt = 0;
    first = 1'b1;
    while (cnt < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        gen_alignment(idle_pct, first, cnt);
      end else if (r < 90) begin
        nq = $urandom_range(1, 4);
        for (int unsigned i = 0; i < nq; i++) begin
          if ($urandom_range(0, 9) == 0)
            push_read(CODE_IN_W'($urandom), QPOS_W'($urandom), idle_pct, first && i == 0);
          else
            push_read(CODE_IN_W'($urandom_range(0, N_CODES - 1)), rand_qpos(), idle_pct,
                      first && i == 0);
          cnt++;
        end
      end else begin
        // noise: arbitrary element fields
        push_element(CODE_IN_W'($urandom), LEN_W'($urandom_range(0, 63)), 1'($urandom),
                     idle_pct, first);
        cnt++;
      end
      first = 1'b0;
    end
  endtask

  // Driver: next transaction goes out once the current one has been taken.
  always @(negedge clk_i) begin
    cigar_cmd_t c;
    if (rst_ni) begin
      if (!start || n_accepted == n_issued) begin
        if (cigar_cmd_q.size() != 0 &&
            !(cigar_cmd_q[0].drain && tally_due_q.size() != 0) &&
            $urandom_range(0, 99) >= cigar_cmd_q[0].idle_pct) begin
          c = cigar_cmd_q.pop_front();
          op_i             <= c.op;
          cigar_code_i     <= c.code;
          cigar_length_i   <= c.len;
          end_of_read_i    <= c.eor;
          query_code_i     <= c.qcode;
          query_position_i <= c.qpos;
          start            <= 1'b1;
          n_issued         <= n_issued + 1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check any result first, then record a newly accepted transaction.
  always @(posedge clk_i) begin
    tally_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (tally_due_q.size() == 0) begin
          $display("%0t: unexpected result count=%0h flag=%0b", $time, count_value_o,
                   overflow_flag_o);
          n_errors++;
        end else begin
          want = tally_due_q.pop_front();
          if (count_value_o !== want.count) begin
            $display("%0t: count_value expected %0h actual %0h", $time, want.count,
                     count_value_o);
            n_errors++;
          end
          if (overflow_flag_o !== want.flag) begin
            $display("%0t: overflow_flag expected %0b actual %0b", $time, want.flag,
                     overflow_flag_o);
            n_errors++;
          end
        end
      end
      if (start && !busy) begin
        want = tally_cigar_op(op_i, cigar_code_i, cigar_length_i, end_of_read_i,
                              query_code_i, query_position_i);
        tally_due_q.push_back(want);
        n_accepted <= n_accepted + 1;
        if (op_i == OP_ADD) n_elems++;
        else n_reads++;
        if (want.flag) n_flagged++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > cycle_limit) begin
      $display("%0t: timeout, %0d results outstanding", $time, tally_due_q.size());
      $display("FAIL cigar_position_histogram");
      $finish;
    end
  end

  initial begin
    for (int unsigned c = 0; c < N_CODES; c++)
      for (int unsigned p = 0; p < READ_LEN; p++) hist_q[c][p] = '0;
    read_pos = 0;

    // directed: empty table, query range edges, element edge cases
    push_read(CODE_IN_W'(0), QPOS_W'(0), 0, 0);
    push_read(CODE_IN_W'(N_CODES - 1), QPOS_W'(READ_LEN - 1), 0, 0);
    push_read(CODE_IN_W'(15), QPOS_W'(0), 0, 0);
    push_read(CODE_IN_W'(N_CODES), QPOS_W'(READ_LEN - 1), 0, 0);
    push_element(CODE_IN_W'(0), LEN_W'(0), 1'b0, 0, 0);
    push_element(CODE_IN_W'(0), LEN_W'(5), 1'b0, 0, 0);
    push_element(CODE_IN_W'(N_CODES - 1), LEN_W'(3), 1'b0, 0, 0);
    push_element(CODE_IN_W'(15), LEN_W'(4), 1'b0, 0, 0);
    push_element(CODE_IN_W'(1), LEN_W'(2), 1'b1, 0, 0);
    push_read(CODE_IN_W'(0), QPOS_W'(4), 0, 0);
    push_read(CODE_IN_W'(N_CODES - 1), QPOS_W'(7), 0, 0);
    push_read(CODE_IN_W'(1), QPOS_W'(12), 0, 0);
    push_element(CODE_IN_W'(2), LEN_W'(READ_LEN), 1'b0, 0, 0);
    push_element(CODE_IN_W'(3), LEN_W'(1), 1'b0, 0, 0);
    push_element(CODE_IN_W'(4), LEN_W'(0), 1'b1, 0, 0);
    push_element(CODE_IN_W'(5), LEN_W'(2047), 1'b1, 0, 0);
    push_element(CODE_IN_W'(6), LEN_W'(1000), 1'b0, 0, 0);
    push_element(CODE_IN_W'(6), LEN_W'(100), 1'b1, 0, 0);
    push_read(CODE_IN_W'(2), QPOS_W'(READ_LEN - 1), 0, 0);
    push_read(CODE_IN_W'(5), QPOS_W'(0), 0, 0);
    push_read(CODE_IN_W'(6), QPOS_W'(READ_LEN - 1), 0, 0);
    push_read(CODE_IN_W'(15), QPOS_W'(READ_LEN - 1), 0, 0);

    gen_phase(16);
    gen_phase(49);
    gen_phase(0);
    cycle_limit = 4 * (cycle_budget + CLEAR_CYCLES + 1000);

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    while (cigar_cmd_q.size() != 0 || start || tally_due_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (tally_due_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, tally_due_q.size());
      n_errors++;
    end

    $display("Ran %0d elements in %0d generated alignments and %0d counter reads;",
             n_elems, n_alignments, n_reads);
    $display("%0d results flagged overflow or bad code, %0d mismatches", n_flagged, n_errors);
    if (n_errors == 0) begin
      $display("PASS cigar_position_histogram");
    end else begin
      $display("FAIL cigar_position_histogram");
    end
    $finish;
  end

endmodule : tb

`default_nettype wire

// ===== files.f =====
hdl/cphist_pkg.sv
hdl/cphist_ram.sv
hdl/cigar_position_histogram.sv
tb/tb.sv
